[design/skl_pkg.sv]
// Shared types and constants for the streaming k-th largest selector.
// Used by the channel interfaces, the storage cell and the top level.
package skl_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 5;

  typedef logic signed [VALUE_W-1:0] value_t;

  // What a cell shows its right-hand neighbor in the current cycle.
  typedef struct packed {
    value_t value;
    logic   gt;
    logic   valid;
  } cell_link_t;

  // What a cell will hold after the current insertion.
  typedef struct packed {
    value_t value;
    logic   valid;
  } cell_next_t;

endpackage

[design/skl_if.sv]
// Valid/ready channel interfaces for the sample and result streams.
// Depends on skl_pkg for the value type.
interface skl_in_if;
  logic           valid;
  logic           ready;
  skl_pkg::value_t sample_value;
  logic           end_of_set;

  modport source (output valid, output sample_value, output end_of_set, input ready);
  modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface skl_out_if;
  logic           valid;
  logic           ready;
  skl_pkg::value_t kth_value;
  logic           short_set;

  modport source (output valid, output kth_value, output short_set, input ready);
  modport sink   (input valid, input kth_value, input short_set, output ready);
endinterface

[design/streaming_kth_largest.sv]
// Top level of the streaming k-th largest selector: a chain of sorted cells.
// Depends on skl_pkg, skl_if and skl_cell.
//
// The block accepts one sample per clock cycle and keeps the rank_k largest
// samples of the current data set in a chain of MAX_RANK cells, sorted in
// descending order. Every cell compares its value with the new sample in the
// same cycle and either keeps its value, takes its left neighbor's value or
// takes the sample. On the sample that ends a set, the smallest kept value
// and a flag telling whether fewer than rank_k samples arrived are loaded
// into the output register at the edge that accepts that sample and are
// offered on the result channel from the next cycle, and the chain is
// emptied for the next set. Input is accepted whenever the output register
// is empty or being read. A rank_k of zero acts as one and values above
// MAX_RANK act as MAX_RANK. The user must write rank_k only while no
// transaction is in flight; the block does not enforce this.
module streaming_kth_largest #(
  parameter int MAX_RANK = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  skl_in_if.sink                        in_stream,
  skl_out_if.source                     out_stream,
  input  logic                          cfg_wr_en,
  input  logic [skl_pkg::RANK_W-1:0]    cfg_wr_data
);

  logic [MAX_RANK-1:0] mask_r;
  logic [MAX_RANK-1:0] last_r;
  logic [MAX_RANK-1:0] mask_nxt;
  logic [MAX_RANK-1:0] last_nxt;
  logic [31:0]         cfg_k;

  skl_pkg::cell_link_t links [MAX_RANK+1];
  skl_pkg::cell_next_t nexts [MAX_RANK];

  logic            accept;
  logic            out_valid_r;
  skl_pkg::value_t kth_r;
  logic            short_r;
  skl_pkg::value_t kth_nxt;
  logic            short_nxt;

  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_k = 32'd1;
    end else if ({27'd0, cfg_wr_data} > 32'(MAX_RANK)) begin
      cfg_k = 32'(MAX_RANK);
    end else begin
      cfg_k = {27'd0, cfg_wr_data};
    end
    for (int i = 0; i < MAX_RANK; i++) begin
      mask_nxt[i] = 32'(i) < cfg_k;
      last_nxt[i] = 32'(i) == (cfg_k - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MAX_RANK'(1);
      last_r <= MAX_RANK'(1);
    end else if (cfg_wr_en) begin
      mask_r <= mask_nxt;
      last_r <= last_nxt;
    end
  end

  assign accept          = in_stream.valid && in_stream.ready;
  assign in_stream.ready = !out_valid_r || out_stream.ready;

  assign links[0] = '{value: '0, gt: 1'b0, valid: 1'b1};

  for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
    skl_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .insert (accept),
      .clear  (in_stream.end_of_set),
      .enable (mask_r[g]),
      .sample (in_stream.sample_value),
      .left   (links[g]),
      .link   (links[g+1]),
      .nxt    (nexts[g])
    );
  end

  // The smallest kept value sits in the last valid cell after insertion.
  always_comb begin
    kth_nxt   = '0;
    short_nxt = 1'b1;
    for (int i = 0; i < MAX_RANK; i++) begin
      if (nexts[i].valid && (i == MAX_RANK - 1 || !nexts[(i + 1) % MAX_RANK].valid)) begin
        kth_nxt = kth_nxt | nexts[i].value;
      end
      if (last_r[i] && nexts[i].valid) begin
        short_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_stream.end_of_set) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_stream.end_of_set) begin
      kth_r   <= kth_nxt;
      short_r <= short_nxt;
    end
  end

  assign out_stream.valid     = out_valid_r;
  assign out_stream.kth_value = kth_r;
  assign out_stream.short_set = short_r;

endmodule

[design/skl_cell.sv]
// One storage cell of the sorted insertion chain.
// Depends on skl_pkg for the link structs.
module skl_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                insert,
  input  logic                clear,
  input  logic                enable,
  input  skl_pkg::value_t     sample,
  input  skl_pkg::cell_link_t left,
  output skl_pkg::cell_link_t link,
  output skl_pkg::cell_next_t nxt
);

  skl_pkg::value_t value_r;
  logic            valid_r;
  logic            eff_valid;
  logic            gt;
  skl_pkg::value_t value_nxt;
  logic            valid_nxt;

  always_comb begin
    eff_valid = valid_r && enable;
    gt        = !eff_valid || (value_r < sample);
    value_nxt = gt ? (left.gt ? left.value : sample) : value_r;
    valid_nxt = enable && (eff_valid || left.valid);
  end

  assign link = '{value: value_r, gt: gt, valid: eff_valid};
  assign nxt  = '{value: value_nxt, valid: valid_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (insert) begin
      valid_r <= valid_nxt && !clear;
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      value_r <= value_nxt;
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the streaming k-th largest selector.
// Depends on skl_pkg, the skl_in_if and skl_out_if interfaces and streaming_kth_largest.
// Directed and random data sets run under several rank settings, with random idling on both sides.

typedef struct {
  skl_pkg::value_t kth_value;
  logic            short_set;
} kth_result_t;

class kth_tracker;
  localparam int DEPTH = 16;

  logic [skl_pkg::RANK_W-1:0] rank_k;
  skl_pkg::value_t            kept[DEPTH];
  int                         kept_count;
  kth_result_t                expected_q[$];
  int                         errors;
  int                         shown;
  int                         checked;
  int                         sets;
  int                         short_sets;

  function new();
    rank_k = 1;
    kept_count = 0;
    errors = 0;
    shown = 0;
    checked = 0;
    sets = 0;
    short_sets = 0;
  endfunction

  function int eff_rank();
    if (rank_k == 0) return 1;
    if (rank_k > DEPTH) return DEPTH;
    return int'(rank_k);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Inserts one accepted sample and queues the result when it closes a set.
  function void note_sample(skl_pkg::value_t v, logic eos);
    int k;
    int pos;
    kth_result_t r;
    k = eff_rank();
    if (kept_count > k) kept_count = k;
    pos = -1;
    if (kept_count < k) begin
      pos = kept_count;
      kept_count++;
    end else if (v > kept[k-1]) begin
      pos = k - 1;
    end
    if (pos >= 0) begin
      while (pos > 0 && kept[pos-1] < v) begin
        kept[pos] = kept[pos-1];
        pos--;
      end
      kept[pos] = v;
    end
    if (eos) begin
      r.kth_value = kept[kept_count-1];
      r.short_set = (kept_count < k);
      expected_q.insert(expected_q.size(), r);
      sets++;
      if (r.short_set) short_sets++;
      kept_count = 0;
    end
  endfunction

  function void check_result(skl_pkg::value_t kth, logic short_set);
    kth_result_t e;
    if (expected_q.size() == 0) begin
      errors++;
      if (shown < 10) begin
        $display("Unexpected result: kth_value %0d short_set %0b", kth, short_set);
        shown++;
      end
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (kth !== e.kth_value || short_set !== e.short_set) begin
      errors++;
      if (shown < 10) begin
        $display("Mismatch on result %0d: expected kth_value %0d short_set %0b, got %0d %0b",
                 checked, e.kth_value, e.short_set, kth, short_set);
        shown++;
      end
    end
  endfunction
endclass

module tb;
  typedef skl_pkg::value_t value_t;

  localparam int RANK_W        = skl_pkg::RANK_W;
  localparam int MAX_RANK      = 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam value_t VMIN = 32'sh8000_0000;
  localparam value_t VMAX = 32'sh7fff_ffff;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [RANK_W-1:0] cfg_wr_data;

  skl_in_if  in_if();
  skl_out_if out_if();

  kth_tracker sb = new();
  bit quiet;
  bit hold_go;
  bit hold_req;
  int cycles;
  int stall_left;
  int rank_writes;
  int mid_set_writes;

  streaming_kth_largest #(.MAX_RANK(MAX_RANK)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stream   (in_if),
    .out_stream  (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic value_t rand_value(int style);
    case (style)
      0: return value_t'($urandom);
      1: return value_t'($urandom_range(0, 15)) - 8;
      default: begin
        case ($urandom_range(0, 5))
          0: return VMIN;
          1: return VMAX;
          2: return -1;
          3: return 0;
          4: return 1;
          default: return value_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_sample(value_t v, logic eos);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.sample_value <= v;
    in_if.end_of_set <= eos;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rank(logic [RANK_W-1:0] k);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    sb.rank_k = k;
    rank_writes++;
    if (sb.kept_count > 0) mid_set_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Transaction monitors for both channels.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_sample(in_if.sample_value, in_if.end_of_set);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.kth_value, out_if.short_set);
  end

  initial begin
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n || hold_req) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          out_if.ready <= 1'b0;
          stall_left--;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    hold_req = 1'b0;
    wait (hold_go);
    hold_req = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_req = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int sent;
    int phase_len;
    int n;
    int set_len;
    int style;
    int r;
    logic [RANK_W-1:0] k;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_if.valid = 1'b0;
    in_if.sample_value = '0;
    in_if.end_of_set = 1'b0;
    quiet = 1'b0;
    hold_go = 1'b0;
    rank_writes = 0;
    mid_set_writes = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, starting with the reset rank of one.
    send_sample(VMIN, 1'b1);
    send_sample(3, 1'b0);
    send_sample(VMAX, 1'b0);
    send_sample(-5, 1'b1);
    drain();
    write_rank(0);
    send_sample(10, 1'b0);
    send_sample(20, 1'b1);
    drain();
    write_rank(16);
    send_sample(-1, 1'b0);
    send_sample(0, 1'b0);
    send_sample(1, 1'b1);
    drain();
    write_rank(31);
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(7, 1'b1);
    drain();
    write_rank(3);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(4, 1'b1);
    // The rank drops and then grows while a set is open.
    send_sample(100, 1'b0);
    send_sample(50, 1'b0);
    send_sample(200, 1'b0);
    send_sample(10, 1'b0);
    drain();
    write_rank(2);
    send_sample(1, 1'b1);
    send_sample(9, 1'b0);
    drain();
    write_rank(5);
    send_sample(8, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0) k = '0;
      else if (r == 1) k = RANK_W'($urandom_range(17, 31));
      else if (r == 2) k = RANK_W'(MAX_RANK);
      else k = RANK_W'($urandom_range(1, MAX_RANK));
      drain();
      write_rank(k);
      quiet = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 180);
      n = 0;
      while (n < phase_len) begin
        style = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) set_len = $urandom_range(1, 40);
        else set_len = $urandom_range(1, 2 * sb.eff_rank() + 2);
        for (int i = 0; i < set_len; i++) begin
          send_sample(rand_value(style), i == set_len - 1);
          n++;
          sent++;
          if (sent == HOLD_AT) hold_go = 1'b1;
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          send_sample(rand_value(0), 1'b0);
          sent++;
        end
      end
    end

    drain();
    $display("Checked %0d results from %0d data sets, %0d of them short.",
             sb.checked, sb.sets, sb.short_sets);
    $display("Rank was written %0d times, %0d of them with a set still open.",
             rank_writes, mid_set_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
design/skl_pkg.sv
design/skl_if.sv
design/skl_cell.sv
design/streaming_kth_largest.sv
tb/tb.sv
